[sv/dchu_pkg.sv]
// Shared types and constants of the dominance count histogram unit.
`timescale 1ns / 1ps

package dchu_pkg;

   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 16;
   localparam int OPCODE_W    = 2;
   localparam int COORD_IN_W  = 7;
   localparam int BIN_W       = 8;
   localparam int RESULT_W    = 9;
   localparam int STATUS_W    = 2;
   localparam int LIMIT_W     = 7;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOAD,
      OP_COMPUTE,
      OP_READ,
      OP_CLEAR
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK,
      ST_FULL,
      ST_RANGE
   } status_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;
      logic clr_step;
      logic i_read;
      logic i_latch;
      logic j_step;
      logic h_read;
      logic h_write;
      logic rsp_load;
   } dchu_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      op_type req_op;
      op_type op;
      logic   sweep_last;
      logic   no_items;
      logic   j_last;
      logic   i_last;
      logic   out_free;
      logic   cnt_zero;
   } dchu_stat_type;

endpackage

[sv/dchu_ctrl.sv]
// Controller state machine of the dominance count histogram unit.
`timescale 1ns / 1ps

module dchu_ctrl
   import dchu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output dchu_cmd_type  cmd,
   input  dchu_stat_type stat
);

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_CLEAR,
      S_I_RD,
      S_I_LATCH,
      S_SWEEP,
      S_DRAIN,
      S_H_RD,
      S_H_WR,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            // zero the histogram once after reset
            cmd.clr_step = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               unique case (stat.req_op) inside
                  OP_LOAD, OP_READ:     state_in = S_FINISH;
                  OP_COMPUTE, OP_CLEAR: state_in = S_CLEAR;
               endcase
            end
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.sweep_last) begin
               if (stat.op == OP_COMPUTE && !stat.no_items) begin
                  state_in = S_I_RD;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_I_RD: begin
            cmd.i_read = 1'b1;
            state_in   = S_I_LATCH;
         end
         S_I_LATCH: begin
            cmd.i_latch = 1'b1;
            state_in    = S_SWEEP;
         end
         S_SWEEP: begin
            cmd.j_step = 1'b1;
            if (stat.j_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // last compare retires in this cycle
            state_in = S_H_RD;
         end
         S_H_RD: begin
            cmd.h_read = 1'b1;
            state_in   = S_H_WR;
         end
         S_H_WR: begin
            cmd.h_write = 1'b1;
            if (stat.i_last) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_I_RD;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[sv/dchu_datapath.sv]
// Datapath of the dominance count histogram unit: item store, histogram, counters.
`timescale 1ns / 1ps

module dchu_datapath
   import dchu_pkg::*;
#(
   parameter int MAX_ITEMS   = 256,
   parameter int VALUE_RANGE = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dchu_cmd_type          cmd,
   output dchu_stat_type         stat,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [OPCODE_W-1:0]   req_tuser,
   input  logic                  csr_wr_en,
   input  logic [LIMIT_W-1:0]    csr_wr_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [STATUS_W-1:0]   rsp_tuser
);

   localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int NW = $clog2(MAX_ITEMS + 1);
   localparam int CW = $clog2(VALUE_RANGE + 1);

   op_type                  req_op;
   logic [COORD_IN_W-1:0]   in_a;
   logic [COORD_IN_W-1:0]   in_b;
   logic [COORD_IN_W-1:0]   in_c;
   logic [BIN_W-1:0]        in_bin;
   logic [31:0]             bin_wide;
   logic                    range_ok;
   logic                    bin_ok;
   logic                    full;
   logic                    load_wr;

   logic [LIMIT_W-1:0]      limit_ff;
   logic [NW-1:0]           count_ff;
   logic [NW-1:0]           count_m1;
   op_type                  op_ff;
   status_type              status_ff;
   logic                    bin_ok_ff;
   logic [NW-1:0]           sweep_ff;
   logic [NW-1:0]           i_ff;
   logic [NW-1:0]           j_ff;
   logic                    cmp_vld_ff;
   logic [NW-1:0]           dom_cnt_ff;
   logic [NW-1:0]           dom_cnt_m1;
   logic [3*CW-1:0]         item_i_ff;
   logic [3*CW-1:0]         coord_rd_ff;
   logic [NW-1:0]           hist_rd_ff;
   logic                    rsp_tvalid_ff;
   logic [RESULT_W-1:0]     rsp_data_ff;
   status_type              rsp_status_ff;

   logic [3*CW-1:0]         coord_mem [MAX_ITEMS];
   logic [NW-1:0]           hist_mem  [MAX_ITEMS];

   logic                    coord_re;
   logic [IW-1:0]           coord_raddr;
   logic                    hist_we;
   logic [IW-1:0]           hist_waddr;
   logic [NW-1:0]           hist_wdata;
   logic                    hist_re;
   logic [IW-1:0]           hist_raddr;
   logic                    dominates;

   assign req_op   = op_type'(req_tuser);
   assign in_a     = req_tdata[6:0];
   assign in_b     = req_tdata[13:7];
   assign in_c     = req_tdata[20:14];
   assign in_bin   = req_tdata[28:21];
   assign bin_wide = 32'(in_bin);

   // a coordinate is legal in 1..min(limit, VALUE_RANGE)
   assign range_ok = (in_a != '0) && (in_a <= limit_ff) && (32'(in_a) <= 32'(VALUE_RANGE))
                  && (in_b != '0) && (in_b <= limit_ff) && (32'(in_b) <= 32'(VALUE_RANGE))
                  && (in_c != '0) && (in_c <= limit_ff) && (32'(in_c) <= 32'(VALUE_RANGE));
   assign bin_ok   = bin_wide < 32'(MAX_ITEMS);
   assign full     = count_ff == NW'(MAX_ITEMS);
   assign load_wr  = cmd.accept && req_op == OP_LOAD && !full && range_ok;

   assign count_m1   = count_ff - NW'(1);
   assign dom_cnt_m1 = dom_cnt_ff - NW'(1);

   // item store: one write port, one registered read port
   assign coord_re    = cmd.i_read || cmd.j_step;
   assign coord_raddr = cmd.i_read ? i_ff[IW-1:0] : j_ff[IW-1:0];

   always_ff @(posedge clock) begin
      if (load_wr) begin
         coord_mem[count_ff[IW-1:0]] <= {CW'(in_c), CW'(in_b), CW'(in_a)};
      end
      if (coord_re) begin
         coord_rd_ff <= coord_mem[coord_raddr];
      end
   end

   // histogram: cleared by sweep, bumped by read-modify-write
   assign hist_we    = cmd.clr_step || cmd.h_write;
   assign hist_waddr = cmd.clr_step ? sweep_ff[IW-1:0] : dom_cnt_m1[IW-1:0];
   assign hist_wdata = cmd.clr_step ? '0 : hist_rd_ff + NW'(1);
   assign hist_re    = (cmd.accept && req_op == OP_READ) || cmd.h_read;
   assign hist_raddr = cmd.h_read ? dom_cnt_m1[IW-1:0] : bin_wide[IW-1:0];

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      if (hist_re) begin
         hist_rd_ff <= hist_mem[hist_raddr];
      end
   end

   assign dominates = (coord_rd_ff[CW-1:0]      <= item_i_ff[CW-1:0])
                   && (coord_rd_ff[2*CW-1:CW]   <= item_i_ff[2*CW-1:CW])
                   && (coord_rd_ff[3*CW-1:2*CW] <= item_i_ff[3*CW-1:2*CW]);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= LIMIT_RESET;
         count_ff      <= '0;
         op_ff         <= OP_LOAD;
         sweep_ff      <= '0;
         i_ff          <= '0;
         j_ff          <= '0;
         cmp_vld_ff    <= 1'b0;
         dom_cnt_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (cmd.accept) begin
            op_ff    <= req_op;
            sweep_ff <= '0;
            i_ff     <= '0;
            if (load_wr) begin
               count_ff <= count_ff + NW'(1);
            end else if (req_op == OP_CLEAR) begin
               count_ff <= '0;
            end
         end
         if (cmd.clr_step) begin
            sweep_ff <= sweep_ff + NW'(1);
         end
         if (cmd.i_read) begin
            j_ff <= '0;
         end
         if (cmd.j_step) begin
            j_ff <= j_ff + NW'(1);
         end
         cmp_vld_ff <= cmd.j_step;
         if (cmd.i_latch) begin
            dom_cnt_ff <= '0;
         end else if (cmp_vld_ff && dominates) begin
            dom_cnt_ff <= dom_cnt_ff + NW'(1);
         end
         if (cmd.h_write) begin
            i_ff <= i_ff + NW'(1);
         end
         if (cmd.rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         bin_ok_ff <= bin_ok;
         case (req_op)
            OP_LOAD:  status_ff <= full ? ST_FULL : (range_ok ? ST_OK : ST_RANGE);
            OP_READ:  status_ff <= bin_ok ? ST_OK : ST_RANGE;
            default:  status_ff <= ST_OK;
         endcase
      end
      if (cmd.i_latch) begin
         item_i_ff <= coord_rd_ff;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         if (op_ff == OP_READ) begin
            rsp_data_ff <= bin_ok_ff ? RESULT_W'(hist_rd_ff) : '0;
         end else begin
            rsp_data_ff <= RESULT_W'(count_ff);
         end
      end
   end

   assign stat.req_op     = req_op;
   assign stat.op         = op_ff;
   assign stat.sweep_last = sweep_ff == NW'(MAX_ITEMS - 1);
   assign stat.no_items   = count_ff == '0;
   assign stat.j_last     = j_ff == count_m1;
   assign stat.i_last     = i_ff == count_m1;
   assign stat.out_free   = !rsp_tvalid_ff || rsp_tready;
   assign stat.cnt_zero   = dom_cnt_ff == '0;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_data_ff);
   assign rsp_tuser  = rsp_status_ff;

endmodule

[sv/dominance_count_histogram_unit.sv]
// Dominance count histogram unit: item store, pairwise counting and bin readout.
// Each request word carries an opcode: load a triple, compute the histogram, read a bin,
// or clear everything. A load or a read goes from acceptance to a registered response.
// A clear zeroes the histogram, one bin per cycle, and the item count. A compute with N stored
// items first zeroes the histogram, then for each
// item the store's single read port fetches it and then every item once, one per cycle,
// followed by a read-modify-write of its bin. After reset the histogram is zeroed before
// the first request word is taken. The unit holds one request at a time and can take and
// work on the next one while a response waits, but holds its own until that one is taken.
`timescale 1ns / 1ps

module dominance_count_histogram_unit
   import dchu_pkg::*;
#(
   parameter int MAX_ITEMS   = 256,
   parameter int VALUE_RANGE = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // item_a, item_b, item_c, bin_index
   input  logic [OPCODE_W-1:0]   req_tuser,   // opcode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // result_value
   output logic [STATUS_W-1:0]   rsp_tuser,   // status
   input  logic                  csr_wr_en,
   input  logic [LIMIT_W-1:0]    csr_wr_data
);

   dchu_cmd_type  cmd;
   dchu_stat_type stat;

   dchu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   dchu_datapath #(
      .MAX_ITEMS   (MAX_ITEMS),
      .VALUE_RANGE (VALUE_RANGE)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   // a store-full response always reports a full store
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_FULL |-> rsp_tdata[RESULT_W-1:0] == RESULT_W'(MAX_ITEMS))
      else $error("store-full response with wrong item count");

   // every item dominates itself, so its count is never zero at the bin update
   assert property (@(posedge clock) disable iff (reset)
      cmd.h_read |-> !stat.cnt_zero)
      else $error("dominance count is zero at histogram update");

   // no new word is taken while a sweep or a histogram update is running
   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !cmd.j_step && !cmd.h_write && !cmd.clr_step)
      else $error("request accepted during internal work");

endmodule

[tb/sv/dominance_count_histogram_unit_tb.sv]
// Self-checking testbench for the dominance count histogram unit.
`timescale 1ns / 1ps

module dominance_count_histogram_unit_tb;
   import dchu_pkg::*;

   localparam int MAX_ITEMS    = 256;
   localparam int VALUE_RANGE  = 64;
   localparam int QUIET_LIMIT  = 300000;
   localparam int RANDOM_WORDS = 450;

   typedef struct {
      logic [RESULT_W-1:0] value;
      status_type          status;
   } bin_reply_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // item_a, item_b, item_c, bin_index
   logic [OPCODE_W-1:0]   req_tuser;   // opcode
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // result_value
   logic [STATUS_W-1:0]   rsp_tuser;   // status
   logic                  csr_wr_en;
   logic [LIMIT_W-1:0]    csr_wr_data;

   // Shadow of the unit's state
   logic [COORD_IN_W-1:0] saved_a [MAX_ITEMS];
   logic [COORD_IN_W-1:0] saved_b [MAX_ITEMS];
   logic [COORD_IN_W-1:0] saved_c [MAX_ITEMS];
   int                    bin_totals [MAX_ITEMS];
   int                    loaded_cnt = 0;
   logic [LIMIT_W-1:0]    limit_reg = LIMIT_RESET;

   bin_reply_type pending_replies[$];
   int         mismatch_count = 0;
   int         quiet_cycles = 0;
   int         sent_words = 0;
   int         rsp_hold = 0;
   bit         req_idle_on = 1'b1;
   bit         rsp_idle_on = 1'b1;

   dominance_count_histogram_unit #(
      .MAX_ITEMS   (MAX_ITEMS),
      .VALUE_RANGE (VALUE_RANGE)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic int draw_wait(bit enabled);
      if (!enabled || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 14);
   endfunction

   // Apply one request word to the shadow state and return the reply it should produce
   function automatic bin_reply_type predict_reply(op_type op, logic [COORD_IN_W-1:0] a,
                                                   logic [COORD_IN_W-1:0] b,
                                                   logic [COORD_IN_W-1:0] c,
                                                   logic [BIN_W-1:0] idx);
      bin_reply_type r;
      int         lim;
      int         cnt;
      lim = (limit_reg < VALUE_RANGE) ? limit_reg : VALUE_RANGE;
      r.value = '0;
      r.status = ST_OK;
      case (op)
         OP_LOAD: begin
            if (loaded_cnt >= MAX_ITEMS) begin
               r.status = ST_FULL;
            end else if (a < 1 || a > lim || b < 1 || b > lim || c < 1 || c > lim) begin
               r.status = ST_RANGE;
            end else begin
               saved_a[loaded_cnt] = a;
               saved_b[loaded_cnt] = b;
               saved_c[loaded_cnt] = c;
               loaded_cnt++;
            end
            r.value = RESULT_W'(loaded_cnt);
         end
         OP_COMPUTE: begin
            for (int k = 0; k < MAX_ITEMS; k++) bin_totals[k] = 0;
            for (int i = 0; i < loaded_cnt; i++) begin
               cnt = 0;
               for (int j = 0; j < loaded_cnt; j++) begin
                  if (saved_a[j] <= saved_a[i] && saved_b[j] <= saved_b[i] &&
                      saved_c[j] <= saved_c[i])
                     cnt++;
               end
               bin_totals[cnt - 1]++;
            end
            r.value = RESULT_W'(loaded_cnt);
         end
         OP_READ: begin
            if (idx < MAX_ITEMS) r.value = RESULT_W'(bin_totals[idx]);
            else r.status = ST_RANGE;
         end
         default: begin
            loaded_cnt = 0;
            for (int k = 0; k < MAX_ITEMS; k++) bin_totals[k] = 0;
         end
      endcase
      return r;
   endfunction

   // Receiver: stall a random number of cycles after each word
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_tready) begin
         if (rsp_tvalid) begin : next_stall
            int s;
            s = draw_wait(rsp_idle_on);
            if (s != 0) begin
               rsp_tready <= 1'b0;
               rsp_hold <= s;
            end
         end
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : monitor
      bin_reply_type want;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         // check the response before queuing the new request word
         if (rsp_tvalid && rsp_tready) begin
            if (pending_replies.size() == 0) begin
               $error("unexpected response word: result_value %0d, status %0d",
                      rsp_tdata, rsp_tuser);
               mismatch_count++;
            end else begin
               want = pending_replies.pop_front();
               if (rsp_tdata !== RSP_DATA_W'(want.value)) begin
                  $error("result_value: expected %0d, actual %0d", want.value, rsp_tdata);
                  mismatch_count++;
               end
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            pending_replies.push_back(predict_reply(op_type'(req_tuser), req_tdata[6:0],
                                                    req_tdata[13:7], req_tdata[20:14],
                                                    req_tdata[28:21]));
         quiet_cycles <= ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) ?
                         0 : quiet_cycles + 1;
      end
   end

   initial begin : watchdog
      do @(posedge clock); while (quiet_cycles < QUIET_LIMIT);
      $display("FAILURE");
      $finish;
   end

   task automatic send_word(op_type op, logic [COORD_IN_W-1:0] a, logic [COORD_IN_W-1:0] b,
                            logic [COORD_IN_W-1:0] c, logic [BIN_W-1:0] idx);
      int gap;
      gap = draw_wait(req_idle_on);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser <= op;
      req_tdata <= {3'b000, idx, c, b, a};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sent_words++;
   endtask

   task automatic load_triple(int a, int b, int c);
      send_word(OP_LOAD, COORD_IN_W'(a), COORD_IN_W'(b), COORD_IN_W'(c),
                BIN_W'($urandom_range(0, 255)));
   endtask

   task automatic read_bin(int idx);
      send_word(OP_READ, COORD_IN_W'($urandom_range(0, 127)),
                COORD_IN_W'($urandom_range(0, 127)),
                COORD_IN_W'($urandom_range(0, 127)), BIN_W'(idx));
   endtask

   task automatic send_command(op_type op);
      send_word(op, COORD_IN_W'($urandom_range(0, 127)), COORD_IN_W'($urandom_range(0, 127)),
                COORD_IN_W'($urandom_range(0, 127)), BIN_W'($urandom_range(0, 255)));
   endtask

   // Drop valid and wait until every reply is back and the unit is idle
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(int v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= LIMIT_W'(v);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limit_reg = LIMIT_W'(v);
   endtask

   task automatic test_directed();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      read_bin(0);
      send_command(OP_COMPUTE);
      load_triple(1, 1, 1);
      load_triple(64, 64, 64);
      load_triple(0, 5, 5);
      load_triple(65, 1, 1);
      load_triple(1, 64, 1);
      load_triple(64, 1, 64);
      load_triple(5, 5, 127);
      send_command(OP_COMPUTE);
      for (int k = 0; k < 4; k++) read_bin(k);
      read_bin(255);
      send_command(OP_CLEAR);
      read_bin(0);
      load_triple(127, 127, 127);
      settle();
   endtask

   task automatic test_limit_register();
      write_limit(0);
      load_triple(1, 1, 1);
      send_command(OP_COMPUTE);
      settle();
      write_limit(1);
      load_triple(1, 1, 1);
      load_triple(2, 1, 1);
      load_triple(1, 1, 2);
      load_triple(1, 1, 1);
      settle();
      write_limit(127);
      load_triple(64, 64, 64);
      load_triple(65, 2, 2);
      load_triple(2, 2, 127);
      load_triple(33, 17, 9);
      send_command(OP_COMPUTE);
      for (int k = 0; k < 4; k++) read_bin(k);
      settle();
      // shrink the limit below the stored items; they stay in the store
      write_limit(4);
      send_command(OP_COMPUTE);
      for (int k = 0; k < 4; k++) read_bin(k);
      send_command(OP_COMPUTE);
      for (int k = 0; k < 4; k++) read_bin(k);
      load_triple(4, 4, 4);
      load_triple(5, 1, 1);
      settle();
      write_limit(LIMIT_RESET);
   endtask

   task automatic test_store_full();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      send_command(OP_CLEAR);
      repeat (MAX_ITEMS) load_triple(64, 1, 64);
      load_triple(1, 1, 1);
      load_triple(0, 0, 0);
      send_command(OP_COMPUTE);
      read_bin(MAX_ITEMS - 1);
      read_bin(0);
      read_bin(MAX_ITEMS - 2);
      settle();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      send_command(OP_CLEAR);
      repeat (MAX_ITEMS)
         load_triple($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 64));
      load_triple(1, 1, 1);
      send_command(OP_COMPUTE);
      repeat (12) read_bin($urandom_range(0, 255));
      send_command(OP_CLEAR);
      settle();
   endtask

   task automatic test_random_batches();
      int first_word;
      int n;
      int span;
      int hi;
      int lim;
      int v;
      first_word = sent_words;
      while (sent_words - first_word < RANDOM_WORDS) begin
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 5))
               0:       v = 0;
               1:       v = 127;
               2:       v = $urandom_range(65, 126);
               3:       v = 1;
               default: v = $urandom_range(2, 64);
            endcase
            write_limit(v);
         end
         // keep the store small so compute stays short
         if (loaded_cnt > 40 || $urandom_range(0, 4) != 0) send_command(OP_CLEAR);
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(21, 60) : $urandom_range(1, 20);
         case ($urandom_range(0, 3))
            0:       span = 2;
            1:       span = 4;
            2:       span = 8;
            default: span = 64;
         endcase
         lim = (limit_reg < VALUE_RANGE) ? limit_reg : VALUE_RANGE;
         hi = (lim < span) ? lim : span;
         repeat (n) begin
            if (hi == 0 || $urandom_range(0, 9) == 0) begin
               case ($urandom_range(0, 2))
                  0: load_triple($urandom_range(0, 127), $urandom_range(0, 127),
                                 $urandom_range(0, 127));
                  1: read_bin($urandom_range(0, 255));
                  default: send_command(op_type'($urandom_range(0, 3)));
               endcase
            end else begin
               load_triple($urandom_range(1, hi), $urandom_range(1, hi), $urandom_range(1, hi));
            end
         end
         send_command(OP_COMPUTE);
         repeat ($urandom_range(1, n)) begin
            if ($urandom_range(0, 4) == 0) read_bin($urandom_range(0, 255));
            else read_bin($urandom_range(0, n + 2));
         end
         if ($urandom_range(0, 3) == 0) begin
            send_command(OP_COMPUTE);
            repeat (3) read_bin($urandom_range(0, n));
         end
         settle();
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= OP_LOAD;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_limit_register();
      test_store_full();
      test_random_batches();
      settle();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pending_replies.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[files.f]
sv/dchu_pkg.sv
sv/dchu_ctrl.sv
sv/dchu_datapath.sv
sv/dominance_count_histogram_unit.sv
tb/sv/dominance_count_histogram_unit_tb.sv
